// ===== sv/cts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Content type sniffer package
// Shared constants, type codes, the result struct and the byte helpers used
// to match HTML tags and file signatures.
// ----------------------------------------------------------------------------
package cts_pkg;

    // Number of leading bytes that are counted and judged for text.
    localparam int SAMPLE_LEN = 256;
    localparam int CNT_W      = $clog2(SAMPLE_LEN + 1);

    // HTML tag table.
    localparam int TAG_COUNT = 5;
    localparam int TAG_MAX   = 17;
    localparam int POS_W     = $clog2(TAG_MAX + 1);

    // Lowercase tag text, right-justified: the first character is the most
    // significant byte of the used part.
    localparam logic [8*TAG_MAX-1:0] TAG_TEXT [TAG_COUNT] = '{
        (8*TAG_MAX)'("<html"),
        (8*TAG_MAX)'("<head"),
        (8*TAG_MAX)'("<title"),
        (8*TAG_MAX)'("<!doctype html"),
        (8*TAG_MAX)'("<!-- html listing")
    };
    localparam logic [POS_W-1:0] TAG_LEN [TAG_COUNT] = '{
        POS_W'(5), POS_W'(5), POS_W'(6), POS_W'(14), POS_W'(17)
    };

    // Signature bytes.
    localparam logic [7:0] PNG_LEAD  = 8'h89;
    localparam logic [7:0] JPEG_LEAD = 8'hFF;
    localparam logic [7:0] JPEG_NEXT = 8'hD8;

    // Result type codes.
    typedef enum logic [2:0] {
        TYPE_OCTET = 3'd0,
        TYPE_HTML  = 3'd1,
        TYPE_PLAIN = 3'd2,
        TYPE_GIF   = 3'd3,
        TYPE_PNG   = 3'd4,
        TYPE_JPEG  = 3'd5
    } t_type_code;

    typedef struct packed {
        t_type_code type_code;
        logic       certain;
    } t_result;

    // Fold ASCII capitals to lowercase; every other byte passes unchanged.
    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] f;
        f = b;
        if (b >= 8'd65 && b <= 8'd90) begin
            f = b + 8'd32;
        end
        return f;
    endfunction

    // Space and the control characters 9 to 13.
    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    // Character of a tag at a position; zero past the end of the tag.
    function automatic logic [7:0] tag_char(input int tag, input logic [POS_W-1:0] pos);
        logic [7:0] ch;
        int         sel;
        ch = 8'd0;
        if (pos < TAG_LEN[tag]) begin
            sel = int'(TAG_LEN[tag]) - 1 - int'(pos);
            ch  = TAG_TEXT[tag][8*sel +: 8];
        end
        return ch;
    endfunction

endpackage : cts_pkg
`default_nettype wire

// ===== sv/cts_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Content type sniffer channels
// Valid/ready channels for the sample bytes and for the typed result.
// ----------------------------------------------------------------------------
interface cts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface : cts_in_if

interface cts_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] type_code;
    logic       certain;

    modport source (output valid, output type_code, output certain, input ready);
    modport sink   (input valid, input type_code, input certain, output ready);
endinterface : cts_out_if
`default_nettype wire

// ===== sv/content_type_sniffer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Content type sniffer
// Guesses the content type of a byte sample from HTML tags, image
// signatures and the share of non-printable bytes.
// ----------------------------------------------------------------------------
// Usage:
// - i_in carries one sample byte per beat; last_byte marks the final beat.
// - o_out carries one beat per sample: type_code (0 octet-stream, 1 html,
//   2 plain text, 3 gif, 4 png, 5 jpeg) and certain.
// - Throughput is one byte per cycle unless a last byte waits for a stalled
//   result. Each byte sits in an input register while the sniffing state
//   is updated from it. The last byte passes the input register, then the
//   result register, before its result is offered on o_out.
// - The result register decouples the sides: bytes keep flowing while a
//   result waits. Only a last byte held in the input register waits for
//   a stalled result to be taken, and then i_in.ready drops.
// - Reset (synchronous, active low) empties both registers and returns the
//   sniffing state to the start of a sample. After every result the state
//   also starts over for the next sample.
// ----------------------------------------------------------------------------
module content_type_sniffer_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cts_in_if.sink     i_in,
    cts_out_if.source  o_out
);
    import cts_pkg::*;

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid, n_out_valid;
    t_result    r_out;
    t_result    result;
    logic       out_free;
    logic       step;

    // Handshake control.
    always_comb begin
        out_free    = !r_out_valid || o_out.ready;
        step        = r_in_valid && (!r_in_last || out_free);
        i_in.ready  = !r_in_valid || step;
        n_in_valid  = i_in.ready ? i_in.valid : r_in_valid;
        n_out_valid = r_out_valid;
        if (step && r_in_last) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    // Sniffing state and decision.
    cts_sniff_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_result    (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (step && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.type_code = r_out.type_code;
    assign o_out.certain   = r_out.certain;

endmodule : content_type_sniffer_top
`default_nettype wire

// ===== sv/cts_sniff_state.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Content type sniffer state
// Holds the per-sample match state, updates it with one byte per step and
// forms the type decision from the updated state.
// ----------------------------------------------------------------------------
module cts_sniff_state (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_last_byte,
    output cts_pkg::t_result    o_result
);
    import cts_pkg::*;

    logic                 r_skip, n_skip;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [TAG_COUNT-1:0] r_cand, n_cand;
    logic                 r_html, n_html;
    logic [31:0]          r_lead, n_lead;
    logic [CNT_W-1:0]     r_seen, n_seen;
    logic [CNT_W-1:0]     r_odd, n_odd;

    logic [7:0]           folded;
    logic [7:0]           lead0, lead1, lead2, lead3;
    logic [CNT_W+3:0]     odd_times_ten;

    // Next state for one byte.
    always_comb begin
        n_skip = r_skip;
        n_pos  = r_pos;
        n_cand = r_cand;
        n_html = r_html;
        n_lead = r_lead;
        n_seen = r_seen;
        n_odd  = r_odd;
        folded = fold_case(i_data_byte);

        // Tag match, once leading whitespace is over.
        if (!(r_skip && is_space(i_data_byte))) begin
            n_skip = 1'b0;
            if (!r_html && (r_cand != '0) && (r_pos < POS_W'(TAG_MAX))) begin
                for (int c = 0; c < TAG_COUNT; c++) begin
                    if (r_cand[c]) begin
                        if ((r_pos < TAG_LEN[c]) && (folded == tag_char(c, r_pos))) begin
                            if ((r_pos + POS_W'(1)) == TAG_LEN[c]) begin
                                n_html = 1'b1;
                            end
                        end else begin
                            n_cand[c] = 1'b0;
                        end
                    end
                end
                n_pos = r_pos + POS_W'(1);
            end
        end

        // The first four bytes are kept for the signature checks.
        if (r_seen < CNT_W'(4)) begin
            n_lead[8*r_seen[1:0] +: 8] = i_data_byte;
        end

        // Count bytes and odd bytes over the sample window.
        if (r_seen < CNT_W'(SAMPLE_LEN)) begin
            if ((i_data_byte < 8'd32 || i_data_byte > 8'd126) && !is_space(i_data_byte)) begin
                n_odd = r_odd + CNT_W'(1);
            end
            n_seen = r_seen + CNT_W'(1);
        end
    end

    // Type decision from the updated state. The text test odd > floor(n/10)
    // is the same as 10 * odd > n for integers.
    always_comb begin
        lead0         = n_lead[7:0];
        lead1         = n_lead[15:8];
        lead2         = n_lead[23:16];
        lead3         = n_lead[31:24];
        odd_times_ten = {1'b0, n_odd, 3'b000} + {3'b000, n_odd, 1'b0};
        o_result.certain = 1'b1;
        if (n_html) begin
            o_result.type_code = TYPE_HTML;
        end else if ((n_seen >= CNT_W'(4)) && (fold_case(lead0) == "g") &&
                     (fold_case(lead1) == "i") && (fold_case(lead2) == "f") &&
                     (lead3 == "8")) begin
            o_result.type_code = TYPE_GIF;
        end else if ((n_seen >= CNT_W'(4)) && (lead0 == PNG_LEAD) &&
                     (fold_case(lead1) == "p") && (fold_case(lead2) == "n") &&
                     (fold_case(lead3) == "g")) begin
            o_result.type_code = TYPE_PNG;
        end else if ((n_seen >= CNT_W'(2)) && (lead0 == JPEG_LEAD) &&
                     (lead1 == JPEG_NEXT)) begin
            o_result.type_code = TYPE_JPEG;
        end else begin
            o_result.type_code = (odd_times_ten > {4'b0000, n_seen}) ? TYPE_OCTET : TYPE_PLAIN;
            o_result.certain   = (n_seen == CNT_W'(SAMPLE_LEN));
        end
    end

    // State register; a sample's last byte returns everything to reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last_byte)) begin
            r_skip <= 1'b1;
            r_pos  <= '0;
            r_cand <= '1;
            r_html <= 1'b0;
            r_lead <= '0;
            r_seen <= '0;
            r_odd  <= '0;
        end else if (i_step) begin
            r_skip <= n_skip;
            r_pos  <= n_pos;
            r_cand <= n_cand;
            r_html <= n_html;
            r_lead <= n_lead;
            r_seen <= n_seen;
            r_odd  <= n_odd;
        end
    end

endmodule : cts_sniff_state
`default_nettype wire

// ===== sv/cts_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Content type sniffer checker
// Port-level properties of the sniffer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module cts_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] i_type_code,
    input wire logic       i_certain
);
    import cts_pkg::*;

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_type_code) && $stable(i_certain))
        else $error("result beat changed while stalled");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // With no result pending the block always takes bytes.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    // Only text and octet-stream can be uncertain.
    a_sure_types: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_type_code != TYPE_PLAIN) && (i_type_code != TYPE_OCTET)
            |-> i_certain)
        else $error("html or image result flagged uncertain");

endmodule : cts_checker

bind content_type_sniffer_top cts_checker u_cts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_type_code (o_out.type_code),
    .i_certain   (o_out.certain)
);
`default_nettype wire
